// ===== hdl/joint_motion_energy_core_assert.svh =====
`ifndef JOINT_MOTION_ENERGY_CORE_ASSERT_SVH
`define JOINT_MOTION_ENERGY_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define JME_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("joint_motion_energy_core: check failed");

// Next-cycle implication, disabled while reset is held.
`define JME_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("joint_motion_energy_core: check failed");

`endif

// ===== hdl/jme_pkg.sv =====
`timescale 1ns / 1ps
package jme_pkg;
    localparam int COORD_W = 16;
    localparam int OFF_W   = 17;
    localparam int SQ_W    = 36;
    localparam int SUM_W   = 56;
    localparam int ROOT_W  = 28;
    localparam int E_W     = 17;
    localparam int CONF_W  = 8;
    localparam int JIDX_W  = 5;
    localparam int JCNT_W  = 6;
    localparam int NORM_W  = 17;
    localparam int APB_AW  = 4;
    localparam int APB_DW  = 32;

    localparam logic [1:0] REG_JOINT_COUNT = 2'd0;
    localparam logic [1:0] REG_CONF_THR    = 2'd1;
    localparam logic [1:0] REG_NORM_EN     = 2'd2;
    localparam logic [1:0] REG_NORM_MAX    = 2'd3;

    localparam logic FUNC_SAMPLE = 1'b0;
    localparam logic FUNC_EMIT   = 1'b1;

    typedef struct packed {
        logic                      func;
        logic [JIDX_W-1:0]         joint_index;
        logic signed [COORD_W-1:0] joint_x;
        logic signed [COORD_W-1:0] joint_y;
        logic signed [COORD_W-1:0] joint_z;
        logic [CONF_W-1:0]         joint_conf;
        logic signed [COORD_W-1:0] neck_x;
        logic signed [COORD_W-1:0] neck_y;
        logic signed [COORD_W-1:0] neck_z;
        logic [CONF_W-1:0]         neck_conf;
    } t_in_word;

    typedef struct packed {
        logic [JIDX_W-1:0] out_joint;
        logic [E_W-1:0]    energy;
        logic              last;
    } t_out_word;
endpackage

// ===== hdl/jme_in_if.sv =====
`timescale 1ns / 1ps
interface jme_in_if import jme_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_word data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/jme_out_if.sv =====
`timescale 1ns / 1ps
interface jme_out_if import jme_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_word data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/joint_motion_energy_core.sv =====
`timescale 1ns / 1ps
// Channel | Dir | Word                                  | Handshake
// i_in    | in  | t_in_word (sample or emit command)    | valid/ready
// o_out   | out | t_out_word (joint, energy, last)      | valid/ready
// APB     | in  | four configuration registers          | psel/penable/pwrite
// A sample outside the active joints is dropped on acceptance; one that fails the confidence
// test, or whose joint had a zero stored offset, ends after the offset read.
// A sample that updates the energy runs three 17-step serial squarings and a 56-step
// division by three in the shared serial divider.
// Per joint, an emit runs a 56-step divide and a 28-step root if the count is nonzero, and a
// 56-step normalizing divide if enabled with a nonzero maximum, then waits for the word to be taken.
// Reset is synchronous; it clears the stored offsets, sums and counts through valid bits.
// The block takes no new word while a result word waits at the output.
`include "joint_motion_energy_core_assert.svh"
module joint_motion_energy_core import jme_pkg::*; #(
    parameter int MAX_JOINTS  = 32,
    parameter int COUNT_WIDTH = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    jme_in_if.sink            i_in,
    jme_out_if.source         o_out,
    input  logic              i_psel,
    input  logic              i_penable,
    input  logic              i_pwrite,
    input  logic [APB_AW-1:0] i_paddr,
    input  logic [APB_DW-1:0] i_pwdata,
    output logic [APB_DW-1:0] o_prdata,
    output logic              o_pready
);
    localparam int KW    = $clog2(MAX_JOINTS);
    localparam int VW    = (COUNT_WIDTH > NORM_W) ? COUNT_WIDTH : NORM_W;
    localparam int OFF3W = 3 * OFF_W;

    typedef enum logic [3:0] {
        ST_IDLE, ST_SRD, ST_SQ, ST_SDIV, ST_SACC,
        ST_ERD, ST_EDIV, ST_SQRT, ST_NORM, ST_NDIV, ST_OUT
    } t_state;

    logic [JCNT_W-1:0] r_joint_count;
    logic [CONF_W-1:0] r_conf_thr;
    logic              r_norm_en;
    logic [NORM_W-1:0] r_norm_max;

    t_state            r_state;
    logic [KW-1:0]     r_j;
    logic [KW-1:0]     r_k;
    logic              r_pass;
    logic [OFF_W-1:0]  r_ox, r_oy, r_oz;
    logic [OFF_W-1:0]  r_dy, r_dz;
    logic [OFF_W-1:0]  r_mplier;
    logic [SQ_W-1:0]   r_mcand;
    logic [SQ_W-1:0]   r_acc;
    logic [4:0]        r_step;
    logic [1:0]        r_axis;
    logic [SUM_W-1:0]  r_sq_val;
    logic [ROOT_W+1:0] r_srem;
    logic [ROOT_W-1:0] r_root;
    logic              r_div_start;
    logic [SUM_W-1:0]  r_div_a;
    logic [VW-1:0]     r_div_b;
    t_out_word         r_out;

    logic [OFF3W-1:0]       r_mem_off [MAX_JOINTS];
    logic [SUM_W-1:0]       r_mem_sum [MAX_JOINTS];
    logic [COUNT_WIDTH-1:0] r_mem_cnt [MAX_JOINTS];
    logic [MAX_JOINTS-1:0]  r_off_vld;
    logic [MAX_JOINTS-1:0]  r_acc_vld;
    logic [OFF3W-1:0]       r_rd_off;
    logic [SUM_W-1:0]       r_rd_sum;
    logic [COUNT_WIDTH-1:0] r_rd_cnt;
    logic                   r_rd_offv;
    logic                   r_rd_accv;

    logic                   w_in_acc, w_out_acc, w_cfg_wr;
    logic [6:0]             w_act, w_j7, w_k7;
    logic                   w_last;
    logic                   w_rd_en;
    logic [KW-1:0]          w_rd_addr;
    logic [OFF_W-1:0]       w_px, w_py, w_pz;
    logic [SUM_W-1:0]       w_psum;
    logic [COUNT_WIDTH-1:0] w_pcnt;
    logic [SUM_W:0]         w_sum_add;
    logic [ROOT_W+1:0]      w_rem_sh, w_trial;
    logic                   w_div_done;
    logic [SUM_W-1:0]       w_quot;
    logic                   w_conf_ok;

    function automatic logic [OFF_W-1:0] f_absdiff(logic signed [COORD_W-1:0] a,
                                                   logic signed [COORD_W-1:0] b);
        logic signed [OFF_W-1:0] d;
        d = OFF_W'(a) - OFF_W'(b);
        return d[OFF_W-1] ? OFF_W'(-d) : OFF_W'(d);
    endfunction

    function automatic logic [OFF_W-1:0] f_udiff(logic [OFF_W-1:0] a, logic [OFF_W-1:0] b);
        return (a >= b) ? a - b : b - a;
    endfunction

    assign w_cfg_wr = i_psel && i_penable && i_pwrite;
    assign o_pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_joint_count <= JCNT_W'(20);
            r_conf_thr    <= CONF_W'(128);
            r_norm_en     <= 1'b0;
            r_norm_max    <= NORM_W'(4096);
        end else if (w_cfg_wr) begin
            unique case (i_paddr[3:2])
                REG_JOINT_COUNT: r_joint_count <= i_pwdata[JCNT_W-1:0];
                REG_CONF_THR:    r_conf_thr    <= i_pwdata[CONF_W-1:0];
                REG_NORM_EN:     r_norm_en     <= i_pwdata[0];
                REG_NORM_MAX:    r_norm_max    <= i_pwdata[NORM_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (i_paddr[3:2])
            REG_JOINT_COUNT: o_prdata = APB_DW'(r_joint_count);
            REG_CONF_THR:    o_prdata = APB_DW'(r_conf_thr);
            REG_NORM_EN:     o_prdata = APB_DW'(r_norm_en);
            REG_NORM_MAX:    o_prdata = APB_DW'(r_norm_max);
            default:         o_prdata = '0;
        endcase
    end

    assign w_act     = (7'(r_joint_count) > 7'(MAX_JOINTS)) ? 7'(MAX_JOINTS)
                                                             : 7'(r_joint_count);
    assign w_j7      = 7'(i_in.data.joint_index);
    assign w_k7      = 7'(r_k);
    assign w_last    = ((w_k7 + 7'd1) == w_act);
    assign w_in_acc  = i_in.valid && i_in.ready;
    assign w_out_acc = o_out.valid && o_out.ready;
    assign i_in.ready  = (r_state == ST_IDLE);
    assign o_out.valid = (r_state == ST_OUT);
    assign o_out.data  = r_out;
    assign w_conf_ok = (i_in.data.joint_conf > r_conf_thr) && (i_in.data.neck_conf > r_conf_thr);

    assign w_rd_en   = (r_state == ST_IDLE) ? w_in_acc : (w_out_acc && !w_last);
    assign w_rd_addr = (r_state == ST_IDLE) ? ((i_in.data.func == FUNC_EMIT) ? '0 : w_j7[KW-1:0])
                                            : KW'(w_k7 + 7'd1);

    assign w_px   = r_rd_offv ? r_rd_off[3*OFF_W-1:2*OFF_W] : '0;
    assign w_py   = r_rd_offv ? r_rd_off[2*OFF_W-1:OFF_W] : '0;
    assign w_pz   = r_rd_offv ? r_rd_off[OFF_W-1:0] : '0;
    assign w_psum = r_rd_accv ? r_rd_sum : '0;
    assign w_pcnt = r_rd_accv ? r_rd_cnt : '0;
    assign w_sum_add = {1'b0, w_psum} + (SUM_W + 1)'(w_quot);
    assign w_rem_sh  = {r_srem[ROOT_W-1:0], r_sq_val[SUM_W-1:SUM_W-2]};
    assign w_trial   = {r_root, 2'b01};

    always_ff @(posedge i_clk) begin
        if (w_rd_en) begin
            r_rd_off  <= r_mem_off[w_rd_addr];
            r_rd_sum  <= r_mem_sum[w_rd_addr];
            r_rd_cnt  <= r_mem_cnt[w_rd_addr];
            r_rd_offv <= r_off_vld[w_rd_addr];
            r_rd_accv <= r_acc_vld[w_rd_addr];
        end
        if (r_state == ST_SACC || (r_state == ST_SRD && r_pass)) begin
            r_mem_off[r_j] <= {r_ox, r_oy, r_oz};
        end
        if (r_state == ST_SACC) begin
            r_mem_sum[r_j] <= w_sum_add[SUM_W] ? '1 : w_sum_add[SUM_W-1:0];
            r_mem_cnt[r_j] <= (w_pcnt == '1) ? w_pcnt : w_pcnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_off_vld <= '0;
            r_acc_vld <= '0;
        end else begin
            if (r_state == ST_SRD) begin
                r_off_vld[r_j] <= r_pass;
            end
            if (r_state == ST_SACC) begin
                r_acc_vld[r_j] <= 1'b1;
            end
            if ((w_out_acc && w_last)
                || (w_in_acc && i_in.data.func == FUNC_EMIT && w_act == 7'd0)) begin
                r_acc_vld <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_div_start <= 1'b0;
        end else begin
            r_div_start <= 1'b0;
            unique case (r_state)
                ST_IDLE: begin
                    if (w_in_acc) begin
                        r_j    <= w_j7[KW-1:0];
                        r_k    <= '0;
                        r_pass <= w_conf_ok;
                        r_ox   <= f_absdiff(i_in.data.neck_x, i_in.data.joint_x);
                        r_oy   <= f_absdiff(i_in.data.neck_y, i_in.data.joint_y);
                        r_oz   <= f_absdiff(i_in.data.neck_z, i_in.data.joint_z);
                        if (i_in.data.func == FUNC_EMIT) begin
                            if (w_act != 7'd0) begin
                                r_state <= ST_ERD;
                            end
                        end else if (w_j7 < w_act) begin
                            r_state <= ST_SRD;
                        end
                    end
                end
                ST_SRD: begin
                    r_dy     <= f_udiff(r_oy, w_py);
                    r_dz     <= f_udiff(r_oz, w_pz);
                    r_mplier <= f_udiff(r_ox, w_px);
                    r_mcand  <= SQ_W'(f_udiff(r_ox, w_px));
                    r_acc    <= '0;
                    r_step   <= '0;
                    r_axis   <= '0;
                    if (r_pass && w_px != '0 && w_py != '0 && w_pz != '0) begin
                        r_state <= ST_SQ;
                    end else begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_SQ: begin
                    if (r_mplier[0]) begin
                        r_acc <= r_acc + r_mcand;
                    end
                    r_mplier <= r_mplier >> 1;
                    r_mcand  <= r_mcand << 1;
                    r_step   <= r_step + 1'b1;
                    if (r_step == 5'(OFF_W - 1)) begin
                        r_step <= '0;
                        r_axis <= r_axis + 1'b1;
                        if (r_axis == 2'd0) begin
                            r_mplier <= r_dy;
                            r_mcand  <= SQ_W'(r_dy);
                        end else if (r_axis == 2'd1) begin
                            r_mplier <= r_dz;
                            r_mcand  <= SQ_W'(r_dz);
                        end else begin
                            r_state <= ST_SDIV;
                        end
                    end
                end
                ST_SDIV: begin
                    if (!r_div_start && r_step == '0) begin
                        r_div_start <= 1'b1;
                        r_div_a     <= SUM_W'(r_acc);
                        r_div_b     <= VW'(3);
                        r_step      <= 5'd1;
                    end else if (w_div_done) begin
                        r_state <= ST_SACC;
                    end
                end
                ST_SACC: begin
                    r_state <= ST_IDLE;
                end
                ST_ERD: begin
                    r_root <= '0;
                    if (w_pcnt == '0) begin
                        r_state <= ST_NORM;
                    end else begin
                        r_div_start <= 1'b1;
                        r_div_a     <= w_psum;
                        r_div_b     <= VW'(w_pcnt);
                        r_state     <= ST_EDIV;
                    end
                end
                ST_EDIV: begin
                    if (w_div_done) begin
                        r_sq_val <= w_quot;
                        r_srem   <= '0;
                        r_step   <= '0;
                        r_state  <= ST_SQRT;
                    end
                end
                ST_SQRT: begin
                    r_sq_val <= r_sq_val << 2;
                    if (w_rem_sh >= w_trial) begin
                        r_srem <= w_rem_sh - w_trial;
                        r_root <= {r_root[ROOT_W-2:0], 1'b1};
                    end else begin
                        r_srem <= w_rem_sh;
                        r_root <= {r_root[ROOT_W-2:0], 1'b0};
                    end
                    r_step <= r_step + 1'b1;
                    if (r_step == 5'(ROOT_W - 1)) begin
                        r_state <= ST_NORM;
                    end
                end
                ST_NORM: begin
                    r_out.out_joint <= w_k7[JIDX_W-1:0];
                    r_out.last      <= w_last;
                    if (!r_norm_en) begin
                        r_out.energy <= (r_root > ROOT_W'(131071)) ? '1 : r_root[E_W-1:0];
                        r_state      <= ST_OUT;
                    end else if (r_norm_max == '0) begin
                        r_out.energy <= (r_root != '0) ? E_W'(65535) : '0;
                        r_state      <= ST_OUT;
                    end else begin
                        r_div_start <= 1'b1;
                        r_div_a     <= SUM_W'({r_root, 16'b0});
                        r_div_b     <= VW'(r_norm_max);
                        r_state     <= ST_NDIV;
                    end
                end
                ST_NDIV: begin
                    if (w_div_done) begin
                        r_out.energy <= (w_quot > SUM_W'(65535)) ? E_W'(65535)
                                                                   : w_quot[E_W-1:0];
                        r_state      <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (w_out_acc) begin
                        if (w_last) begin
                            r_state <= ST_IDLE;
                        end else begin
                            r_k     <= KW'(w_k7 + 7'd1);
                            r_state <= ST_ERD;
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    jme_div #(
        .DW (SUM_W),
        .VW (VW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_div_start),
        .i_dividend (r_div_a),
        .i_divisor  (r_div_b),
        .o_done     (w_div_done),
        .o_quot     (w_quot)
    );

    `JME_ASSERT_NOW(a_out_blocks_in, i_clk, i_rst_n, o_out.valid, !i_in.ready)
    `JME_ASSERT_NEXT(a_last_to_idle, i_clk, i_rst_n, w_out_acc && w_last, r_state == ST_IDLE)
    `JME_ASSERT_NEXT(a_emit_clears, i_clk, i_rst_n, w_out_acc && w_last, r_acc_vld == '0)
    `JME_ASSERT_NEXT(a_root_follows_div, i_clk, i_rst_n,
                     r_state == ST_EDIV && w_div_done, r_state == ST_SQRT)
endmodule

// ===== hdl/jme_div.sv =====
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle.
module jme_div #(
    parameter int DW = 56,
    parameter int VW = 17
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [DW-1:0] i_dividend,
    input  logic [VW-1:0] i_divisor,
    output logic          o_done,
    output logic [DW-1:0] o_quot
);
    localparam int CW = $clog2(DW + 1);

    logic [DW-1:0] r_quo;
    logic [VW-1:0] r_rem;
    logic [VW-1:0] r_dvs;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;
    logic [VW:0]   w_sh;
    logic [VW:0]   w_diff;
    logic          w_ge;

    assign w_sh   = {r_rem, r_quo[DW-1]};
    assign w_diff = w_sh - {1'b0, r_dvs};
    assign w_ge   = (w_sh >= {1'b0, r_dvs});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(DW);
                r_quo  <= i_dividend;
                r_dvs  <= i_divisor;
                r_rem  <= '0;
            end else if (r_busy) begin
                r_quo <= {r_quo[DW-2:0], w_ge};
                r_rem <= w_ge ? w_diff[VW-1:0] : w_sh[VW-1:0];
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;
endmodule
